// File: hdl/slm_pkg.sv
`default_nettype none
package slm_pkg;

  localparam int unsigned MaxPairs  = 1024;
  localparam int unsigned CountMax  = 2 * MaxPairs;
  localparam int unsigned CntW      = $clog2(CountMax + 1);
  localparam int unsigned SumW      = 40;
  localparam int unsigned SmpW      = 16;
  localparam int unsigned LvlW      = 16;
  localparam int unsigned SqW       = 2 * SmpW;
  localparam int unsigned DivW      = (CntW > LvlW) ? CntW : LvlW;
  localparam int unsigned DivSteps  = SumW;
  localparam int unsigned DivCntW   = $clog2(DivSteps + 1);
  localparam int unsigned SqrtSteps = SqW / 2;
  localparam int unsigned SqrtCntW  = $clog2(SqrtSteps + 1);
  localparam int unsigned SqrtRemW  = LvlW + 4;

  localparam logic [LvlW-1:0] DecayReset     = 16'd54395;
  localparam logic [LvlW-1:0] GainReset      = 16'd4588;
  localparam logic [LvlW-1:0] FullScaleReset = 16'd1966;
  localparam logic [LvlW-1:0] LevelMax       = '1;
  localparam logic [SqW:0]    RoundHalf      = (SqW + 1)'(32768);

  typedef logic [SumW-1:0] sum_t;
  typedef logic [CntW-1:0] cnt_t;

  typedef struct packed {
    sum_t sum;
    cnt_t cnt;
  } buf_t;

  typedef struct packed {
    logic            start;
    sum_t            dividend;
    logic [DivW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    sum_t quotient;
  } div_rsp_t;

  typedef struct packed {
    logic [LvlW-1:0] decay;
    logic [LvlW-1:0] gain;
    logic [LvlW-1:0] full_scale;
  } cfg_t;

  typedef enum logic [1:0] {
    RegDecay     = 2'd0,
    RegGain      = 2'd1,
    RegFullScale = 2'd2
  } reg_idx_e;

endpackage
`default_nettype wire

// File: hdl/slm_fifo.sv
`default_nettype none
module slm_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  slm_pkg::buf_t      data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               empty_o,
  output slm_pkg::buf_t      data_o
);
  import slm_pkg::*;

  buf_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q, fill_d;

  assign full_o  = fill_q == 2'd2;
  assign empty_o = fill_q == 2'd0;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    fill_d = fill_q;
    if (push_i && !pop_i) fill_d = fill_q + 2'd1;
    else if (pop_i && !push_i) fill_d = fill_q - 2'd1;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i) rd_ptr_q <= ~rd_ptr_q;
      fill_q <= fill_d;
    end
  end
endmodule
`default_nettype wire

// File: hdl/slm_front.sv
`default_nettype none
module slm_front (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,
  input  wire logic        s_axis_tlast,
  input  wire logic        fifo_full_i,
  output logic             push_o,
  output slm_pkg::buf_t    push_data_o
);
  import slm_pkg::*;

  logic signed [SmpW-1:0] left, right;
  logic signed [SqW-1:0]  sq_l, sq_r;
  logic [SqW-1:0]         pair_sq_d, pair_sq_q;
  logic                   s1_valid_q, s1_last_q;
  logic                   take, adv2, accum;
  logic [SumW:0]          sum_ext;
  sum_t                   sum_q, sum_d, sum_sat;
  cnt_t                   cnt_q, cnt_d;

  assign left      = s_axis_tdata[SmpW-1:0];
  assign right     = s_axis_tdata[2*SmpW-1:SmpW];
  assign sq_l      = SqW'(left) * SqW'(left);
  assign sq_r      = SqW'(right) * SqW'(right);
  assign pair_sq_d = $unsigned(sq_l) + $unsigned(sq_r);

  assign adv2          = s1_valid_q && !(s1_last_q && fifo_full_i);
  assign s_axis_tready = !s1_valid_q || adv2;
  assign take          = s_axis_tvalid && s_axis_tready;

  assign accum   = cnt_q < CntW'(CountMax);
  assign sum_ext = {1'b0, sum_q} + (SumW + 1)'(pair_sq_q);
  assign sum_sat = sum_ext[SumW] ? '1 : sum_ext[SumW-1:0];
  assign sum_d   = accum ? sum_sat : sum_q;
  assign cnt_d   = accum ? cnt_q + CntW'(2) : cnt_q;

  assign push_o          = adv2 && s1_last_q;
  assign push_data_o.sum = sum_d;
  assign push_data_o.cnt = cnt_d;

  always_ff @(posedge clk_i) begin
    if (take) begin
      pair_sq_q <= pair_sq_d;
      s1_last_q <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      sum_q      <= '0;
      cnt_q      <= '0;
    end else begin
      if (take) s1_valid_q <= 1'b1;
      else if (adv2) s1_valid_q <= 1'b0;
      if (adv2) begin
        if (s1_last_q) begin
          sum_q <= '0;
          cnt_q <= '0;
        end else begin
          sum_q <= sum_d;
          cnt_q <= cnt_d;
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: hdl/slm_div.sv
`default_nettype none
module slm_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  slm_pkg::div_req_t req_i,
  output slm_pkg::div_rsp_t rsp_o
);
  import slm_pkg::*;

  logic               busy_q, done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [DivW-1:0]    rem_q, divisor_q;
  sum_t               quo_q;
  logic [DivW:0]      rem_sh, rem_d;
  logic               ge;

  assign rem_sh = {rem_q, quo_q[SumW-1]};
  assign ge     = rem_sh >= {1'b0, divisor_q};
  assign rem_d  = ge ? rem_sh - {1'b0, divisor_q} : rem_sh;

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q     <= '0;
      quo_q     <= req_i.dividend;
      divisor_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_d[DivW-1:0];
      quo_q <= {quo_q[SumW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= DivCntW'(DivSteps);
      end else if (busy_q) begin
        cnt_q <= cnt_q - DivCntW'(1);
        if (cnt_q == DivCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: hdl/slm_back.sv
`default_nettype none
module slm_back (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  slm_pkg::cfg_t     cfg_i,
  input  wire logic         fifo_empty_i,
  input  slm_pkg::buf_t     fifo_data_i,
  output logic              pop_o,
  output slm_pkg::div_req_t div_req_o,
  input  slm_pkg::div_rsp_t div_rsp_i,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [47:0]       m_axis_tdata
);
  import slm_pkg::*;

  typedef enum logic [7:0] {
    StIdle     = 8'b0000_0001,
    StDivMean  = 8'b0000_0010,
    StSqrt     = 8'b0000_0100,
    StMulLvl   = 8'b0000_1000,
    StMulGain  = 8'b0001_0000,
    StRound    = 8'b0010_0000,
    StDivScale = 8'b0100_0000,
    StOut      = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [SqW-1:0]      sq_n_q, prod_a_q, prod_b_q;
  logic [SqrtRemW-1:0] sq_rem_q, rem_sh, trial, rem_nx;
  logic [LvlW-1:0]     sq_root_q;
  logic [SqrtCntW-1:0] sq_cnt_q;
  logic                sq_ge;
  logic [LvlW-1:0]     level_q, rms_q, smooth_q, scaled_q, lvl_d;
  logic [SqW:0]        acc;
  logic [LvlW:0]       acc_sh;
  logic                fs_zero;

  assign rem_sh = {sq_rem_q[SqrtRemW-3:0], sq_n_q[SqW-1:SqW-2]};
  assign trial  = SqrtRemW'({sq_root_q, 2'b01});
  assign sq_ge  = rem_sh >= trial;
  assign rem_nx = sq_ge ? rem_sh - trial : rem_sh;

  assign acc     = {1'b0, prod_a_q} + {1'b0, prod_b_q} + RoundHalf;
  assign acc_sh  = acc[SqW:LvlW];
  assign lvl_d   = acc_sh[LvlW] ? LevelMax : acc_sh[LvlW-1:0];
  assign fs_zero = cfg_i.full_scale == '0;

  assign pop_o         = (state_q == StIdle) && !fifo_empty_i;
  assign m_axis_tvalid = state_q == StOut;
  assign m_axis_tdata  = {scaled_q, smooth_q, rms_q};

  always_comb begin
    div_req_o.start    = 1'b0;
    div_req_o.dividend = fifo_data_i.sum;
    div_req_o.divisor  = DivW'(fifo_data_i.cnt);
    if (state_q == StIdle) begin
      div_req_o.start = !fifo_empty_i;
    end else if (state_q == StRound) begin
      div_req_o.start    = !fs_zero;
      div_req_o.dividend = SumW'({lvl_d, {LvlW{1'b0}}});
      div_req_o.divisor  = DivW'(cfg_i.full_scale);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:     if (!fifo_empty_i) state_d = StDivMean;
      StDivMean:  if (div_rsp_i.done) state_d = StSqrt;
      StSqrt:     if (sq_cnt_q == SqrtCntW'(1)) state_d = StMulLvl;
      StMulLvl:   state_d = StMulGain;
      StMulGain:  state_d = StRound;
      StRound:    state_d = fs_zero ? StOut : StDivScale;
      StDivScale: if (div_rsp_i.done) state_d = StOut;
      StOut:      if (m_axis_tready) state_d = StIdle;
      default:    state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StDivMean: begin
        sq_n_q    <= div_rsp_i.quotient[SqW-1:0];
        sq_rem_q  <= '0;
        sq_root_q <= '0;
        sq_cnt_q  <= SqrtCntW'(SqrtSteps);
      end
      StSqrt: begin
        sq_n_q    <= {sq_n_q[SqW-3:0], 2'b00};
        sq_rem_q  <= rem_nx;
        sq_root_q <= {sq_root_q[LvlW-2:0], sq_ge};
        sq_cnt_q  <= sq_cnt_q - SqrtCntW'(1);
        rms_q     <= {sq_root_q[LvlW-2:0], sq_ge};
      end
      StMulLvl:  prod_a_q <= SqW'(level_q) * SqW'(cfg_i.decay);
      StMulGain: prod_b_q <= SqW'(cfg_i.gain) * SqW'(rms_q);
      StRound: begin
        smooth_q <= lvl_d;
        scaled_q <= LevelMax;
      end
      StDivScale: begin
        if (div_rsp_i.done) begin
          scaled_q <= (div_rsp_i.quotient[SumW-1:LvlW] != '0) ? LevelMax
                                                            : div_rsp_i.quotient[LvlW-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      level_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == StRound) level_q <= lvl_d;
    end
  end
endmodule
`default_nettype wire

// File: hdl/stereo_rms_level_meter.sv
`default_nettype none
// Stereo RMS level meter. Stereo pairs enter on the s_axis side, one per cycle while tready
// is high, with tlast on the final pair of a buffer; one result per buffer leaves on the
// m_axis side. The front end squares and accumulates each pair in two pipeline steps, so a
// pair is taken every cycle unless the end of a buffer finds the queue full. At the end of
// a buffer its sum and count move into a two-entry queue; the back end then pops it, runs
// the shared bit-serial divider for the mean square (40 steps, then a done report), a
// 16-step square root, the smoothing multiplies and rounding, the divider again for the
// full-scale mapping (skipped when full scale is zero), and hands off the result. Buffers
// arriving faster than the back end hold tready low once the queue is full. Registers lie at
// APB byte addresses 0x0 (decay), 0x4 (gain) and 0x8 (full scale), 16 bits each.
module stereo_rms_level_meter (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // left_sample, right_sample
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // rms_level, smoothed_level, scaled_level
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import slm_pkg::*;

  cfg_t     cfg_q;
  logic     fifo_full, fifo_empty, push, pop, wr_en;
  buf_t     push_data, fifo_data;
  div_req_t div_req;
  div_rsp_t div_rsp;
  reg_idx_e reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx)
      RegDecay:     prdata = 32'(cfg_q.decay);
      RegGain:      prdata = 32'(cfg_q.gain);
      RegFullScale: prdata = 32'(cfg_q.full_scale);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.decay      <= DecayReset;
      cfg_q.gain       <= GainReset;
      cfg_q.full_scale <= FullScaleReset;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegDecay:     cfg_q.decay      <= pwdata[LvlW-1:0];
        RegGain:      cfg_q.gain       <= pwdata[LvlW-1:0];
        RegFullScale: cfg_q.full_scale <= pwdata[LvlW-1:0];
        default: ;
      endcase
    end
  end

  slm_front u_front (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tlast,
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  slm_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .empty_o (fifo_empty),
    .data_o  (fifo_data)
  );

  slm_div u_div (
    .clk_i,
    .rst_ni,
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  slm_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_i        (cfg_q),
    .fifo_empty_i (fifo_empty),
    .fifo_data_i  (fifo_data),
    .pop_o        (pop),
    .div_req_o    (div_req),
    .div_rsp_i    (div_rsp),
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );
endmodule
`default_nettype wire

// File: hdl/slm_checker.sv
`default_nettype none
module slm_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata,
  input wire logic        psel,
  input wire logic        penable,
  input wire logic        pwrite,
  input wire logic [3:0]  paddr,
  input wire logic [31:0] pwdata,
  input wire logic [31:0] prdata,
  input wire logic        pready
);

  // rms of Q1.15 samples never exceeds 32768, one half of the unsigned 16-bit level range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[15:0] <= 16'd32768)
    else $error("rms_level above half scale");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped");

  // a value written to the decay register reads back on the next cycle at that register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && paddr[3:2] == 2'd0) ##1 (paddr[3:2] == 2'd0)
    |-> prdata[15:0] == $past(pwdata[15:0]))
    else $error("decay register readback mismatch");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result withdrawn before transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

endmodule

bind stereo_rms_level_meter slm_checker u_slm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata),
  .pready        (pready)
);
`default_nettype wire

// File: bench/stereo_rms_level_meter_test.sv
`timescale 1ns / 1ps
module stereo_rms_level_meter_test;
  import slm_pkg::*;

  localparam logic [3:0] UnusedAddr = 4'hC;
  localparam int unsigned HoldCycles = 600;
  localparam int unsigned DrainCycles = 250;

  typedef struct packed {
    logic [LvlW-1:0] scaled;
    logic [LvlW-1:0] smoothed;
    logic [LvlW-1:0] rms;
  } level_result_t;

  typedef enum int unsigned {
    SmpRandom,
    SmpQuiet,
    SmpExtreme,
    SmpLoud
  } sample_style_e;

  typedef enum int unsigned {
    RxAlways,
    RxMostly,
    RxAlternate,
    RxSparse
  } rx_pattern_e;

  class level_predictor;
    logic [LvlW-1:0] decay;
    logic [LvlW-1:0] gain;
    logic [LvlW-1:0] full_scale;
    logic [SumW-1:0] square_sum;
    logic [CntW-1:0] sample_count;
    logic [LvlW-1:0] level;
    level_result_t   expected_levels[$];
    int unsigned     errors;

    function new();
      decay        = DecayReset;
      gain         = GainReset;
      full_scale   = FullScaleReset;
      square_sum   = '0;
      sample_count = '0;
      level        = '0;
      errors       = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [LvlW-1:0] value);
      case (idx)
        RegDecay: begin
          decay = value;
        end
        RegGain: begin
          gain = value;
        end
        default: begin
          full_scale = value;
        end
      endcase
    endfunction

    function void add_square(logic signed [SmpW-1:0] s);
      longint signed   v;
      longint unsigned total;
      v = s;
      total = 64'(square_sum) + 64'(v * v);
      if ((total >> SumW) != 0) square_sum = '1;
      else square_sum = total[SumW-1:0];
    endfunction

    function logic [LvlW-1:0] root_of(longint unsigned n);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= n) root = trial;
      end
      if (root > 64'd65535) root = 64'd65535;
      return root[LvlW-1:0];
    endfunction

    function void take_pair(logic signed [SmpW-1:0] left, logic signed [SmpW-1:0] right,
                            logic last);
      longint unsigned mean_sq;
      longint unsigned acc;
      longint unsigned lvl;
      longint unsigned ratio;
      level_result_t   r;
      if (sample_count < CountMax) begin
        add_square(left);
        add_square(right);
        sample_count += 2;
      end
      if (!last) return;
      mean_sq = 64'(square_sum) / 64'(sample_count);
      r.rms = root_of(mean_sq);
      acc = 64'(level) * 64'(decay) + 64'(gain) * 64'(r.rms);
      lvl = (acc + 64'd32768) >> 16;
      if (lvl > 64'd65535) lvl = 64'd65535;
      r.smoothed = lvl[LvlW-1:0];
      level = r.smoothed;
      if (full_scale == '0) begin
        r.scaled = LevelMax;
      end else begin
        ratio = (lvl << 16) / 64'(full_scale);
        r.scaled = (ratio > 64'd65535) ? LevelMax : ratio[LvlW-1:0];
      end
      square_sum   = '0;
      sample_count = '0;
      expected_levels.insert(expected_levels.size(), r);
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_levels(level_result_t got);
      level_result_t want;
      if (expected_levels.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      want = expected_levels.pop_front();
      if (got.rms !== want.rms)
        report($sformatf("rms_level got %0d want %0d", got.rms, want.rms));
      if (got.smoothed !== want.smoothed)
        report($sformatf("smoothed_level got %0d want %0d", got.smoothed, want.smoothed));
      if (got.scaled !== want.scaled)
        report($sformatf("scaled_level got %0d want %0d", got.scaled, want.scaled));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  level_predictor levels;
  bit             gaps_on;
  int unsigned    burst_left;
  bit             long_hold_req;

  stereo_rms_level_meter i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) levels.check_levels(m_axis_tdata);
  end

  function automatic logic signed [SmpW-1:0] random_sample(sample_style_e style);
    logic signed [SmpW-1:0] v;
    case (style)
      SmpQuiet: begin
        v = SmpW'(int'($urandom_range(0, 511)) - 256);
      end
      SmpExtreme: begin
        case ($urandom_range(0, 4))
          0: v = 16'sh8000;
          1: v = 16'sh7FFF;
          2: v = 16'sh0000;
          3: v = -16'sd1;
          default: v = 16'sd1;
        endcase
      end
      SmpLoud: begin
        v = SmpW'($urandom_range(16384, 32767));
        if ($urandom_range(0, 1) != 0) v = -v;
      end
      default: begin
        v = SmpW'($urandom());
      end
    endcase
    return v;
  endfunction

  task automatic send_pair(input logic signed [SmpW-1:0] left,
                           input logic signed [SmpW-1:0] right, input logic last);
    s_axis_tdata  = {right, left};
    s_axis_tlast  = last;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    levels.take_pair(left, right, last);
    @(negedge clk_i);
    if (gaps_on) begin
      if (burst_left == 0) begin
        s_axis_tvalid = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
        burst_left = $urandom_range(1, 24);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_buffer(input int unsigned len, input sample_style_e style);
    for (int unsigned i = 0; i < len; i++)
      send_pair(random_sample(style), random_sample(style), i == len - 1);
  endtask

  task automatic run_random(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    int unsigned pick;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) len = $urandom_range(1, 8);
      else if (pick < 98) len = $urandom_range(9, 48);
      else len = $urandom_range(100, 300);
      send_buffer(len, sample_style_e'($urandom_range(0, 3)));
      sent += len;
    end
  endtask

  task automatic wait_idle();
    s_axis_tvalid = 1'b0;
    while (levels.expected_levels.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [3:0] addr, input logic [LvlW-1:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = {16'($urandom()), value};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_level_reg(input reg_idx_e idx, input logic [LvlW-1:0] value);
    write_reg({idx, 2'b00}, value);
    levels.set_reg(idx, value);
  endtask

  task automatic set_config(input logic [LvlW-1:0] decay, input logic [LvlW-1:0] gain,
                            input logic [LvlW-1:0] full_scale);
    wait_idle();
    set_level_reg(RegDecay, decay);
    set_level_reg(RegGain, gain);
    set_level_reg(RegFullScale, full_scale);
  endtask

  initial begin
    rx_pattern_e pattern;
    int unsigned pattern_left;
    int unsigned held;
    m_axis_tready = 1'b0;
    pattern_left  = 0;
    pattern       = RxAlways;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        m_axis_tready = 1'b0;
        for (held = 0; held < HoldCycles; held++) @(negedge clk_i);
        long_hold_req = 1'b0;
      end
      if (pattern_left == 0) begin
        pattern      = rx_pattern_e'($urandom_range(0, 3));
        pattern_left = $urandom_range(16, 120);
      end
      pattern_left--;
      case (pattern)
        RxAlways: begin
          m_axis_tready = 1'b1;
        end
        RxMostly: begin
          m_axis_tready = ($urandom_range(0, 3) != 0);
        end
        RxAlternate: begin
          m_axis_tready = ~m_axis_tready;
        end
        default: begin
          m_axis_tready = ($urandom_range(0, 3) == 0);
        end
      endcase
    end
  end

  initial begin
    #10_000_000;
    $display("** stereo_rms_level_meter: FAILED **");
    $finish;
  end

  initial begin
    int unsigned k;
    levels        = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    gaps_on       = 1'b0;
    burst_left    = 0;
    long_hold_req = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_pair(16'sd0, 16'sd0, 1'b1);
    send_pair(16'sh8000, 16'sh8000, 1'b1);
    send_pair(16'sh7FFF, 16'sh7FFF, 1'b1);
    send_pair(16'sh8000, 16'sh7FFF, 1'b1);
    send_pair(16'sd1, -16'sd1, 1'b1);
    send_pair(16'sd100, -16'sd200, 1'b0);
    send_pair(16'sd300, -16'sd400, 1'b1);
    send_pair(-16'sd1, 16'sd0, 1'b0);
    send_pair(16'sd12345, -16'sd12345, 1'b0);
    send_pair(16'sd0, 16'sh7FFF, 1'b1);
    gaps_on = 1'b1;
    send_buffer(4, SmpLoud);
    send_buffer(3, SmpExtreme);

    // drive the level into saturation with the scaled output clamped
    set_config(16'hFFFF, 16'hFFFF, 16'd1);
    for (k = 0; k < 4; k++) send_pair(16'sh8000, 16'sh8000, 1'b1);
    // saturate the accumulator
    for (k = 0; k < 520; k++) send_pair(16'sh8000, 16'sh8000, k == 519);

    set_config(16'h0000, 16'h0000, 16'hFFFF);
    send_buffer(2, SmpLoud);
    send_buffer(1, SmpRandom);
    send_pair(16'sh8000, 16'sd0, 1'b1);

    set_config(16'h8000, 16'hFFFF, 16'h0000);
    send_buffer(3, SmpLoud);
    send_buffer(2, SmpQuiet);
    wait_idle();
    write_reg(UnusedAddr, 16'h0001);
    send_buffer(2, SmpExtreme);
    send_buffer(5, SmpRandom);

    for (k = 0; k < 5; k++) begin
      set_config(16'($urandom()), 16'($urandom()),
                 ($urandom_range(0, 1) != 0) ? 16'($urandom_range(1, 4000))
                                             : 16'($urandom_range(1, 65535)));
      gaps_on = (k != 1);
      if (k == 2) begin
        // hold the output off and keep short buffers coming
        long_hold_req = 1'b1;
        for (int j = 0; j < 40; j++) send_buffer($urandom_range(1, 2), SmpRandom);
      end
      run_random(25);
    end

    wait_idle();
    if (levels.errors == 0) begin
      $display("** stereo_rms_level_meter: PASSED **");
    end else begin
      $display("** stereo_rms_level_meter: FAILED **");
    end
    $finish;
  end

endmodule
